>>> hdl/cts_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the COO to CSR converter.
// Used by the configuration block and the top level; no dependencies.
package cts_pkg;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 16;
    localparam int VAL_W   = 32;
    localparam int INDEX_W = 13;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int RPTR_W  = 13;
    localparam int RIU_W   = 11;
    localparam int PADDR_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FINISH = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RDPTR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RDENT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ROW   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_PHASE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_INDEX = 3'd4;

    localparam logic [PADDR_W-1:0] ADDR_ROWS_IN_USE = 2'd0;
    localparam logic [RIU_W-1:0]   ROWS_IN_USE_RST  = 11'd1024;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_csr;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_coord;

endpackage

>>> hdl/coo_to_csr_converter.sv
`timescale 1ns / 1ps
// COO to CSR converter top level: request sequencer around three RAMs.
// Depends on cts_pkg, cts_ram and cts_cfg.
//
// One request is handled at a time; a finished result sits in an output
// register so the next request can be taken while it waits. A load steps
// through accept, row count read-modify-write and reply; an entry read or a
// pointer read of an inner row through accept, RAM read and reply; a read of
// the first or the last pointer, an error or an unused kind goes from accept
// straight to reply. A finish walks the row count RAM row by row for the
// prefix sum (read, then write), then the entry store entry by entry for the
// scatter (read entry, read row cursor, write). A clear, and reset, sweep the
// row count RAM one entry a cycle; no request is taken during the sweep after
// reset, but configuration writes are.
module coo_to_csr_converter #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // row[9:0], col[25:10], value[57:26], index[70:58], zero pad[71]
    input  logic [71:0]                 s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // row_start[12:0], col_out[28:13], value_out[60:29], zero pad[63:61]
    output logic [63:0]                 m_axis_tdata,
    // status[2:0]
    output logic [2:0]                  m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (RW > EW) ? RW : EW;
    localparam int CRD_W = $bits(cts_pkg::t_coord);
    localparam int CSR_W = $bits(cts_pkg::t_csr);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LDWB  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PWR   = 4'd4;
    localparam logic [3:0] S_SRC   = 4'd5;
    localparam logic [3:0] S_SRN   = 4'd6;
    localparam logic [3:0] S_SWR   = 4'd7;
    localparam logic [3:0] S_RDP   = 4'd8;
    localparam logic [3:0] S_RDE   = 4'd9;
    localparam logic [3:0] S_REPLY = 4'd10;

    logic [3:0]                  r_state, n_state;
    logic [IW-1:0]               r_i, n_i;
    logic [EW-1:0]               r_sum, n_sum;
    logic [EW-1:0]               r_entry_count, n_entry_count;
    logic                        r_finished, n_finished;
    logic                        r_clr_reply, n_clr_reply;
    logic [RAW-1:0]              r_row, n_row;
    cts_pkg::t_csr               r_csr, n_csr;
    logic [cts_pkg::STAT_W-1:0]  r_p_status, n_p_status;
    logic [cts_pkg::RPTR_W-1:0]  r_p_rptr, n_p_rptr;
    logic [cts_pkg::COL_W-1:0]   r_p_col, n_p_col;
    logic [cts_pkg::VAL_W-1:0]   r_p_val, n_p_val;
    logic                        r_o_valid, n_o_valid;
    logic [cts_pkg::STAT_W-1:0]  r_o_status, n_o_status;
    logic [cts_pkg::RPTR_W-1:0]  r_o_rptr, n_o_rptr;
    logic [cts_pkg::COL_W-1:0]   r_o_col, n_o_col;
    logic [cts_pkg::VAL_W-1:0]   r_o_val, n_o_val;

    logic                        cnt_we;
    logic [RAW-1:0]              cnt_waddr, cnt_raddr;
    logic [EW-1:0]               cnt_wdata, cnt_rdata;
    logic                        crd_we;
    logic [EAW-1:0]              crd_waddr, crd_raddr;
    cts_pkg::t_coord             crd_wdata, crd_rdata;
    logic                        csr_we;
    logic [EAW-1:0]              csr_waddr, csr_raddr;
    cts_pkg::t_csr               csr_wdata, csr_rdata;

    logic [RW-1:0]               w_eff;
    logic [2:0]                  w_kind;
    logic [cts_pkg::ROW_W-1:0]   w_in_row;
    logic [cts_pkg::COL_W-1:0]   w_in_col;
    logic [cts_pkg::VAL_W-1:0]   w_in_val;
    logic [cts_pkg::INDEX_W-1:0] w_in_idx;
    logic [31:0]                 w_eff32, w_cnt32, w_row32, w_idx32, w_idxm1, w_i32, w_crow32;
    logic                        w_slot_free;

    assign w_kind   = s_axis_tuser;
    assign w_in_row = s_axis_tdata[9:0];
    assign w_in_col = s_axis_tdata[25:10];
    assign w_in_val = s_axis_tdata[57:26];
    assign w_in_idx = s_axis_tdata[70:58];

    assign w_eff32  = 32'(w_eff);
    assign w_cnt32  = 32'(r_entry_count);
    assign w_row32  = 32'(w_in_row);
    assign w_idx32  = 32'(w_in_idx);
    assign w_idxm1  = w_idx32 - 32'd1;
    assign w_i32    = 32'(r_i);
    assign w_crow32 = 32'(crd_rdata.row);

    assign w_slot_free   = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    cts_cfg #(.MAX_ROWS(MAX_ROWS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_busy     ((r_entry_count != '0) || r_finished),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_eff_rows (w_eff)
    );

    // Per-row counts; after a finish each entry holds the end of its row.
    cts_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cts_ram #(.WIDTH(CRD_W), .DEPTH(MAX_ENTRIES)) u_crd_ram (
        .i_clk   (i_clk),
        .i_we    (crd_we),
        .i_waddr (crd_waddr),
        .i_wdata (crd_wdata),
        .i_raddr (crd_raddr),
        .o_rdata (crd_rdata)
    );

    cts_ram #(.WIDTH(CSR_W), .DEPTH(MAX_ENTRIES)) u_csr_ram (
        .i_clk   (i_clk),
        .i_we    (csr_we),
        .i_waddr (csr_waddr),
        .i_wdata (csr_wdata),
        .i_raddr (csr_raddr),
        .o_rdata (csr_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_sum         = r_sum;
        n_entry_count = r_entry_count;
        n_finished    = r_finished;
        n_clr_reply   = r_clr_reply;
        n_row         = r_row;
        n_csr         = r_csr;
        n_p_status    = r_p_status;
        n_p_rptr      = r_p_rptr;
        n_p_col       = r_p_col;
        n_p_val       = r_p_val;
        n_o_valid     = r_o_valid && !m_axis_tready;
        n_o_status    = r_o_status;
        n_o_rptr      = r_o_rptr;
        n_o_col       = r_o_col;
        n_o_val       = r_o_val;

        cnt_we    = 1'b0;
        cnt_waddr = r_row;
        cnt_wdata = '0;
        cnt_raddr = w_row32[RAW-1:0];
        crd_we    = 1'b0;
        crd_waddr = r_entry_count[EAW-1:0];
        crd_wdata = '{row: w_in_row, col: w_in_col, value: w_in_val};
        crd_raddr = r_i[EAW-1:0];
        csr_we    = 1'b0;
        csr_waddr = cnt_rdata[EAW-1:0];
        csr_wdata = r_csr;
        csr_raddr = w_idx32[EAW-1:0];

        case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_i[RAW-1:0];
                cnt_wdata = '0;
                if (w_i32 == 32'(MAX_ROWS - 1)) begin
                    n_entry_count = '0;
                    n_finished    = 1'b0;
                    n_p_status    = cts_pkg::STAT_OK;
                    n_state       = r_clr_reply ? S_REPLY : S_IDLE;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_p_status = cts_pkg::STAT_OK;
                    n_p_rptr   = '0;
                    n_p_col    = '0;
                    n_p_val    = '0;
                    n_state    = S_REPLY;
                    case (w_kind)
                        cts_pkg::KIND_LOAD: begin
                            if (r_finished) begin
                                n_p_status = cts_pkg::STAT_PHASE;
                            end else if (w_row32 >= w_eff32) begin
                                n_p_status = cts_pkg::STAT_ROW;
                            end else if (w_cnt32 >= 32'(MAX_ENTRIES)) begin
                                n_p_status = cts_pkg::STAT_FULL;
                            end else begin
                                crd_we  = 1'b1;
                                n_row   = w_row32[RAW-1:0];
                                n_state = S_LDWB;
                            end
                        end
                        cts_pkg::KIND_FINISH: begin
                            if (r_finished) begin
                                n_p_status = cts_pkg::STAT_PHASE;
                            end else begin
                                n_i     = '0;
                                n_sum   = '0;
                                n_state = S_PRD;
                            end
                        end
                        cts_pkg::KIND_RDPTR: begin
                            // Pointer i is the end of row i-1 after the scatter.
                            if (!r_finished) begin
                                n_p_status = cts_pkg::STAT_PHASE;
                            end else if (w_idx32 > w_eff32) begin
                                n_p_status = cts_pkg::STAT_INDEX;
                            end else if (w_idx32 == 32'd0) begin
                                n_p_rptr = '0;
                            end else if (w_idx32 == w_eff32) begin
                                n_p_rptr = cts_pkg::RPTR_W'(r_entry_count);
                            end else begin
                                cnt_raddr = w_idxm1[RAW-1:0];
                                n_state   = S_RDP;
                            end
                        end
                        cts_pkg::KIND_RDENT: begin
                            if (!r_finished) begin
                                n_p_status = cts_pkg::STAT_PHASE;
                            end else if (w_idx32 >= w_cnt32) begin
                                n_p_status = cts_pkg::STAT_INDEX;
                            end else begin
                                n_state = S_RDE;
                            end
                        end
                        cts_pkg::KIND_CLEAR: begin
                            n_i         = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        default: begin
                            n_p_status = cts_pkg::STAT_PHASE;
                        end
                    endcase
                end
            end
            S_LDWB: begin
                cnt_we        = 1'b1;
                cnt_wdata     = cnt_rdata + EW'(1);
                n_entry_count = r_entry_count + EW'(1);
                n_state       = S_REPLY;
            end
            S_PRD: begin
                if (w_i32 == w_eff32) begin
                    n_i     = '0;
                    n_state = S_SRC;
                end else begin
                    cnt_raddr = r_i[RAW-1:0];
                    n_state   = S_PWR;
                end
            end
            S_PWR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_i[RAW-1:0];
                cnt_wdata = r_sum;
                n_sum     = r_sum + cnt_rdata;
                n_i       = r_i + IW'(1);
                n_state   = S_PRD;
            end
            S_SRC: begin
                if (w_i32 == w_cnt32) begin
                    n_finished = 1'b1;
                    n_p_status = cts_pkg::STAT_OK;
                    n_state    = S_REPLY;
                end else begin
                    n_state = S_SRN;
                end
            end
            S_SRN: begin
                cnt_raddr = w_crow32[RAW-1:0];
                n_row     = w_crow32[RAW-1:0];
                n_csr     = '{col: crd_rdata.col, value: crd_rdata.value};
                n_state   = S_SWR;
            end
            S_SWR: begin
                // The row cursor gives the destination and then moves on.
                csr_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata + EW'(1);
                n_i       = r_i + IW'(1);
                n_state   = S_SRC;
            end
            S_RDP: begin
                n_p_rptr = cts_pkg::RPTR_W'(cnt_rdata);
                n_state  = S_REPLY;
            end
            S_RDE: begin
                n_p_col = csr_rdata.col;
                n_p_val = csr_rdata.value;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_p_status;
                    n_o_rptr   = r_p_rptr;
                    n_o_col    = r_p_col;
                    n_o_val    = r_p_val;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_i           <= '0;
            r_entry_count <= '0;
            r_finished    <= 1'b0;
            r_clr_reply   <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_i           <= n_i;
            r_entry_count <= n_entry_count;
            r_finished    <= n_finished;
            r_clr_reply   <= n_clr_reply;
            r_o_valid     <= n_o_valid;
        end
        r_sum      <= n_sum;
        r_row      <= n_row;
        r_csr      <= n_csr;
        r_p_status <= n_p_status;
        r_p_rptr   <= n_p_rptr;
        r_p_col    <= n_p_col;
        r_p_val    <= n_p_val;
        r_o_status <= n_o_status;
        r_o_rptr   <= n_o_rptr;
        r_o_col    <= n_o_col;
        r_o_val    <= n_o_val;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_val, r_o_col, r_o_rptr};

endmodule

>>> hdl/cts_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cts_cfg.sv
`timescale 1ns / 1ps
// APB register block holding rows_in_use and its clamped effective row count.
// Depends on cts_pkg.
module cts_cfg #(
    parameter int MAX_ROWS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_busy,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cts_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [$clog2(MAX_ROWS+1)-1:0] o_eff_rows
);

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam logic [RW-1:0] EFF_RST = (1024 > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(1024);

    logic [cts_pkg::RIU_W-1:0] r_rows;
    logic [RW-1:0]             r_eff;
    logic [31:0]               w_wr32;
    logic                      w_wr;

    assign pready = 1'b1;
    assign w_wr32 = 32'(pwdata[cts_pkg::RIU_W-1:0]);
    // The row count is frozen while a conversion holds entries or is finished.
    assign w_wr   = psel && penable && pwrite && (paddr == cts_pkg::ADDR_ROWS_IN_USE)
                    && !i_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= cts_pkg::ROWS_IN_USE_RST;
            r_eff  <= EFF_RST;
        end else if (w_wr) begin
            r_rows <= pwdata[cts_pkg::RIU_W-1:0];
            r_eff  <= (w_wr32 > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(w_wr32);
        end
    end

    assign prdata     = (paddr == cts_pkg::ADDR_ROWS_IN_USE) ? 32'(r_rows) : 32'd0;
    assign o_eff_rows = r_eff;

endmodule

>>> dv/coo_to_csr_converter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the COO to CSR converter: watches the request, reply and APB channels,
// keeps its own copy of the conversion state and compares every reply in order.
// Depends on cts_pkg.
module coo_to_csr_converter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // row[9:0], col[25:10], value[57:26], index[70:58], zero pad[71]
    input  logic [71:0]                 s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]                  s_axis_tuser,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // row_start[12:0], col_out[28:13], value_out[60:29], zero pad[63:61]
    input  logic [63:0]                 m_axis_tdata,
    // status[2:0]
    input  logic [2:0]                  m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int NROWS = 1024;
    localparam int NENT  = 4096;

    typedef struct packed {
        logic [cts_pkg::STAT_W-1:0] status;
        logic [cts_pkg::RPTR_W-1:0] row_start;
        logic [cts_pkg::COL_W-1:0]  col;
        logic [cts_pkg::VAL_W-1:0]  value;
    } t_reply;

    int                        row_ptr    [0:NROWS];
    logic [cts_pkg::ROW_W-1:0] held_row   [0:NENT-1];
    logic [cts_pkg::COL_W-1:0] held_col   [0:NENT-1];
    logic [cts_pkg::VAL_W-1:0] held_val   [0:NENT-1];
    logic [cts_pkg::COL_W-1:0] sorted_col [0:NENT-1];
    logic [cts_pkg::VAL_W-1:0] sorted_val [0:NENT-1];
    int            entries;
    bit            built;
    int            rows_cfg;
    t_reply        replies_due[$];
    int            errors;

    assign o_fail_count = errors;
    assign o_pending    = replies_due.size();

    function automatic int active_rows();
        return (rows_cfg > NROWS) ? NROWS : rows_cfg;
    endfunction

    // Exclusive prefix sum of the row counts, then a stable scatter by row.
    task automatic build_csr();
        int n, sum, c, r, d;
        n   = active_rows();
        sum = 0;
        for (int i = 0; i < n; i++) begin
            c          = row_ptr[i];
            row_ptr[i] = sum;
            sum       += c;
        end
        row_ptr[n] = entries;
        for (int i = 0; i < entries; i++) begin
            r = held_row[i];
            if (r < n) begin
                d = row_ptr[r];
                if (d < NENT) begin
                    sorted_col[d] = held_col[i];
                    sorted_val[d] = held_val[i];
                    row_ptr[r]    = d + 1;
                end
            end
        end
        // Every cursor now sits at the next row's start.
        for (int i = n; i > 0; i--) row_ptr[i] = row_ptr[i-1];
        row_ptr[0] = 0;
        row_ptr[n] = entries;
    endtask

    task automatic predict_request(input logic [2:0] kind, input logic [71:0] data);
        logic [cts_pkg::ROW_W-1:0]   row;
        logic [cts_pkg::COL_W-1:0]   col;
        logic [cts_pkg::VAL_W-1:0]   val;
        logic [cts_pkg::INDEX_W-1:0] idx;
        t_reply                      rep;
        row = data[9:0];
        col = data[25:10];
        val = data[57:26];
        idx = data[70:58];
        rep = '0;
        rep.status = cts_pkg::STAT_OK;
        case (kind)
            cts_pkg::KIND_LOAD: begin
                if (built) rep.status = cts_pkg::STAT_PHASE;
                else if (row >= active_rows()) rep.status = cts_pkg::STAT_ROW;
                else if (entries >= NENT) rep.status = cts_pkg::STAT_FULL;
                else begin
                    held_row[entries] = row;
                    held_col[entries] = col;
                    held_val[entries] = val;
                    row_ptr[row]++;
                    entries++;
                end
            end
            cts_pkg::KIND_FINISH: begin
                if (built) rep.status = cts_pkg::STAT_PHASE;
                else begin
                    build_csr();
                    built = 1;
                end
            end
            cts_pkg::KIND_RDPTR: begin
                if (!built) rep.status = cts_pkg::STAT_PHASE;
                else if (idx > active_rows()) rep.status = cts_pkg::STAT_INDEX;
                else rep.row_start = cts_pkg::RPTR_W'(row_ptr[idx]);
            end
            cts_pkg::KIND_RDENT: begin
                if (!built) rep.status = cts_pkg::STAT_PHASE;
                else if (idx >= entries) rep.status = cts_pkg::STAT_INDEX;
                else begin
                    rep.col   = sorted_col[idx];
                    rep.value = sorted_val[idx];
                end
            end
            cts_pkg::KIND_CLEAR: begin
                for (int i = 0; i <= NROWS; i++) row_ptr[i] = 0;
                entries = 0;
                built   = 0;
            end
            default: rep.status = cts_pkg::STAT_PHASE;
        endcase
        replies_due.push_back(rep);
    endtask

    task automatic check_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            $display("%0t: reply with nothing outstanding: status %0d data %h",
                     $time, m_axis_tuser, m_axis_tdata);
            errors++;
        end else begin
            want = replies_due.pop_front();
            if (m_axis_tuser !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         m_axis_tuser);
                errors++;
            end
            if (m_axis_tdata[12:0] !== want.row_start) begin
                $display("%0t: row_start expected %0d actual %0d", $time, want.row_start,
                         m_axis_tdata[12:0]);
                errors++;
            end
            if (m_axis_tdata[28:13] !== want.col) begin
                $display("%0t: col_out expected %h actual %h", $time, want.col,
                         m_axis_tdata[28:13]);
                errors++;
            end
            if (m_axis_tdata[60:29] !== want.value) begin
                $display("%0t: value_out expected %h actual %h", $time, want.value,
                         m_axis_tdata[60:29]);
                errors++;
            end
        end
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NROWS; i++) row_ptr[i] = 0;
            entries  = 0;
            built    = 0;
            rows_cfg = cts_pkg::ROWS_IN_USE_RST;
            replies_due.delete();
        end else begin
            // A rows_in_use write only lands while the store is empty and unbuilt.
            if (psel && penable && pwrite && pready && paddr == cts_pkg::ADDR_ROWS_IN_USE
                && entries == 0 && !built)
                rows_cfg = pwdata[cts_pkg::RIU_W-1:0];
            if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) check_reply();
        end
    end

endmodule

>>> dv/coo_to_csr_converter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the COO to CSR converter: drives requests and APB writes,
// varies idle and stall rates and reports the verdict. Depends on cts_pkg and the checker.
module coo_to_csr_converter_tb;

    localparam logic [cts_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [cts_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [cts_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;
    int conversions = 0;
    int cur_rows = 1024;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    coo_to_csr_converter u_top (.*);

    coo_to_csr_converter_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .psel, .penable,
        .pwrite, .paddr, .pwdata, .pready, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    task automatic send(input logic [2:0] kind, input int row, input logic [15:0] col,
                        input logic [31:0] val, input int idx);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, idx[12:0], val, col, row[9:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rows(input int rows);
        psel   <= 1;
        pwrite <= 1;
        paddr  <= cts_pkg::ADDR_ROWS_IN_USE;
        pwdata <= rows;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge i_clk);
    endtask

    // Clear, then set a new row count once the block is idle.
    task automatic restart(input int rows);
        send(cts_pkg::KIND_CLEAR, 0, 0, 0, 0);
        drain();
        write_rows(rows);
        cur_rows = rows;
    endtask

    initial begin
        int nload, nread, rlim, pick, rows;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: phase errors, unused kinds, field extremes, ignored write.
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 0);
        send(cts_pkg::KIND_RDENT, 0, 0, 0, 0);
        send(KIND_SPARE_LO, 0, 0, 0, 0);
        send(KIND_SPARE_HI, 1023, 16'hffff, 32'hffffffff, 8191);
        send(cts_pkg::KIND_LOAD, 1023, 16'hffff, 32'hffffffff, 8191);
        send(cts_pkg::KIND_LOAD, 0, 0, 0, 0);
        send(cts_pkg::KIND_LOAD, 1023, 16'h1234, 32'h89abcdef, 0);
        send(cts_pkg::KIND_LOAD, 5, 16'h5555, 32'haaaaaaaa, 0);
        drain();
        write_rows(3);
        send(cts_pkg::KIND_FINISH, 0, 0, 0, 0);
        send(cts_pkg::KIND_FINISH, 0, 0, 0, 0);
        send(cts_pkg::KIND_LOAD, 0, 0, 0, 0);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 0);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 1024);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 1023);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 1025);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 8191);
        for (int i = 0; i < 5; i++) send(cts_pkg::KIND_RDENT, 0, 0, 0, i);
        send(cts_pkg::KIND_RDENT, 0, 0, 0, 8191);
        conversions++;

        // One row: an out-of-range row, then a handful of entries in row zero.
        restart(1);
        send(cts_pkg::KIND_LOAD, 1, 16'h0001, 32'h1, 0);
        for (int i = 0; i < 8; i++)
            send(cts_pkg::KIND_LOAD, 0, 16'($urandom), $urandom, 0);
        send(cts_pkg::KIND_FINISH, 0, 0, 0, 0);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 1);
        send(cts_pkg::KIND_RDPTR, 0, 0, 0, 2);
        send(cts_pkg::KIND_RDENT, 0, 0, 0, 0);
        send(cts_pkg::KIND_RDENT, 0, 0, 0, 7);
        send(cts_pkg::KIND_RDENT, 0, 0, 0, 8);
        conversions++;

        // Random conversions under rotating idle and stall rates.
        while (sent < 850) begin
            case (conversions % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            pick = $urandom_range(9);
            rows = (pick == 0) ? 1024 : (pick == 1) ? 2047 : (pick == 2) ? 1
                 : (pick == 3) ? $urandom_range(2047, 1) : $urandom_range(40, 1);
            restart(rows);
            rlim  = (cur_rows > 1024) ? 1024 : cur_rows;
            nload = $urandom_range(40);
            for (int i = 0; i < nload; i++) begin
                if ($urandom_range(9) == 0)
                    send(3'($urandom_range(7)), $urandom_range(1023), 16'($urandom),
                         $urandom, $urandom_range(8191));
                else
                    send(cts_pkg::KIND_LOAD, ($urandom_range(4) == 0) ? $urandom_range(1023)
                         : $urandom_range(rlim - 1), 16'($urandom), $urandom, $urandom);
            end
            send(cts_pkg::KIND_FINISH, $urandom, 16'($urandom), $urandom, $urandom);
            nread = $urandom_range(30);
            for (int i = 0; i < nread; i++) begin
                pick = $urandom_range(9);
                if (pick < 4)
                    send(cts_pkg::KIND_RDPTR, $urandom, 16'($urandom), $urandom,
                         $urandom_range(rlim + 1));
                else if (pick < 8)
                    send(cts_pkg::KIND_RDENT, $urandom, 16'($urandom), $urandom,
                         $urandom_range(nload + 1));
                else
                    send(3'($urandom_range(7)), $urandom, 16'($urandom), $urandom,
                         $urandom_range(8191));
            end
            conversions++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests in %0d conversions, row counts 1 to 2047,", sent,
                 conversions);
        $display("covering phase, row and index errors, unused kinds and ignored writes.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
